FILE: rtl/cofr_pkg.sv
// Shared types and constants for the circle outline and fill rasterizer.
// No dependencies; the queue, front end, back end and top level import this package.
`default_nettype none

package cofr_pkg;

	// Input item codes.
	localparam logic MODE_START = 1'b0;

	// Result index within one iteration.
	localparam int IDX_BITS = 3;
	typedef logic [IDX_BITS-1:0] idx_t;
	localparam idx_t IDX_LAST_OUTLINE = 3'd7;	// eight octant points
	localparam idx_t IDX_LAST_FILL    = 3'd3;	// four spans

	// Per-iteration flags carried from the front end to the back end.
	typedef struct packed {
		logic fill;
		logic done;
	} cofr_flags_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} cofr_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/cofr_in_if.sv
// Input request channel of the rasterizer: valid/ready plus the item fields.
// No dependencies.
`default_nettype none

interface cofr_in_if #(
	parameter int COORD_BITS = 11
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [COORD_BITS-1:0] circle_radius;
	logic                  fill_select;

	modport source (output valid, mode, center_x, center_y, circle_radius, fill_select,
		input ready);
	modport sink (input valid, mode, center_x, center_y, circle_radius, fill_select,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/cofr_out_if.sv
// Result channel of the rasterizer: valid/ready plus one point or span.
// No dependencies.
`default_nettype none

interface cofr_out_if #(
	parameter int COORD_BITS = 11
);
	localparam int OB = COORD_BITS + 2;

	logic                 valid;
	logic                 ready;
	logic signed [OB-1:0] span_start_x;
	logic signed [OB-1:0] span_end_x;
	logic signed [OB-1:0] row_y;
	logic                 last_of_run;
	logic                 circle_done;

	modport source (output valid, span_start_x, span_end_x, row_y, last_of_run, circle_done,
		input ready);
	modport sink (input valid, span_start_x, span_end_x, row_y, last_of_run, circle_done,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/cofr_queue.sv
// Small FIFO of iteration jobs between front end and back end.
// Depends on cofr_pkg for the status struct.
`default_nettype none

module cofr_queue #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [WIDTH-1:0]   wr_data,
	input  wire logic               pop,
	output logic [WIDTH-1:0]        rd_data,
	output cofr_pkg::cofr_qstat_t   qstat
);
	import cofr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cofr_front.sv
// Front end: accepts requests, holds circle state, runs the decision update.
// Depends on cofr_pkg and cofr_in_if.
`default_nettype none

module cofr_front #(
	parameter int COORD_BITS = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cofr_in_if.sink                    item,
	input  wire cofr_pkg::cofr_qstat_t qstat,
	output logic                       push,
	output logic [COORD_BITS-1:0]      job_cx,
	output logic [COORD_BITS-1:0]      job_cy,
	output logic [COORD_BITS-1:0]      job_ox,
	output logic [COORD_BITS-1:0]      job_oy,
	output cofr_pkg::cofr_flags_t      job_flags
);
	import cofr_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int OW = CB + 2;	// offsets, signed; y offset can end at -1
	localparam int DW = CB + 3;	// decision term, wraps at this width
	localparam int W  = CB + 4;	// compare and update width

	logic [CB-1:0]        cx_q, cy_q, r_q;
	logic                 fill_q;
	logic signed [OW-1:0] ox_q, oy_q;
	logic signed [DW-1:0] d_q;
	logic                 active_q;

	logic                 accept, start, fill_c, done;
	logic [CB-1:0]        cx_c, cy_c, r_c;
	logic signed [OW-1:0] ox_c, oy_c;
	logic signed [DW-1:0] d_c;
	logic signed [W-1:0]  d_w, ox_w, oy_w, r_w, two_ox, gap, gap2, diff, nd, nox, noy;

	assign item.ready = !qstat.full;
	assign accept     = item.valid && item.ready;
	assign start      = (item.mode == MODE_START);

	// A start request seeds the iteration from the new radius.
	assign cx_c   = start ? item.center_x : cx_q;
	assign cy_c   = start ? item.center_y : cy_q;
	assign r_c    = start ? item.circle_radius : r_q;
	assign fill_c = start ? item.fill_select : fill_q;
	assign ox_c   = start ? '0 : ox_q;
	assign oy_c   = start ? {{(OW-CB){1'b0}}, item.circle_radius} : oy_q;
	assign d_c    = start ? ({{(DW-CB){1'b0}}, item.circle_radius} - DW'(1)) : d_q;

	assign d_w    = {{(W-DW){d_c[DW-1]}}, d_c};
	assign ox_w   = {{(W-OW){ox_c[OW-1]}}, ox_c};
	assign oy_w   = {{(W-OW){oy_c[OW-1]}}, oy_c};
	assign r_w    = {{(W-CB){1'b0}}, r_c};
	assign two_ox = {ox_w[W-2:0], 1'b0};
	assign gap    = r_w - oy_w;
	assign gap2   = {gap[W-2:0], 1'b0};
	assign diff   = oy_w - ox_w - W'(1);

	// Three-branch update: step x, step y, or step both.
	always_comb begin
		nox = ox_w;
		noy = oy_w;
		if (d_w >= two_ox) begin
			nd  = d_w - two_ox - W'(1);
			nox = ox_w + W'(1);
		end else if (d_w < gap2) begin
			nd  = d_w + {oy_w[W-2:0], 1'b0} - W'(1);
			noy = oy_w - W'(1);
		end else begin
			nd  = d_w + {diff[W-2:0], 1'b0};
			nox = ox_w + W'(1);
			noy = oy_w - W'(1);
		end
	end

	assign done = (noy < nox);
	assign push = accept && (start || active_q);

	assign job_cx         = cx_c;
	assign job_cy         = cy_c;
	assign job_ox         = ox_c[CB-1:0];
	assign job_oy         = oy_c[CB-1:0];
	assign job_flags.fill = fill_c;
	assign job_flags.done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			fill_q   <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			d_q      <= '0;
			active_q <= 1'b0;
		end else begin
			if (accept && start) begin
				cx_q   <= item.center_x;
				cy_q   <= item.center_y;
				r_q    <= item.circle_radius;
				fill_q <= item.fill_select;
			end
			if (push) begin
				ox_q     <= nox[OW-1:0];
				oy_q     <= noy[OW-1:0];
				d_q      <= nd[DW-1:0];
				active_q <= !done;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cofr_back.sv
// Back end: expands one iteration job into points or spans, one per cycle while results are taken.
// Depends on cofr_pkg and cofr_out_if.
`default_nettype none

module cofr_back #(
	parameter int COORD_BITS = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [COORD_BITS-1:0] job_cx,
	input  wire logic [COORD_BITS-1:0] job_cy,
	input  wire logic [COORD_BITS-1:0] job_ox,
	input  wire logic [COORD_BITS-1:0] job_oy,
	input  wire cofr_pkg::cofr_flags_t job_flags,
	input  wire cofr_pkg::cofr_qstat_t qstat,
	output logic                   pop,
	cofr_out_if.source             result
);
	import cofr_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int OB = CB + 2;

	logic [CB-1:0]        cx_q, cy_q, ox_q, oy_q;
	cofr_flags_t          flags_q;
	logic                 cur_valid_q;
	idx_t                 idx_q;
	logic                 out_valid_q;
	logic signed [OB-1:0] sx_q, ex_q, y_q;
	logic                 last_q, done_q;

	logic                 slot_free, advance, last;
	logic                 x_uses_oy, x_neg, y_neg;
	logic [CB-1:0]        ax, ay;
	logic signed [OB-1:0] cx_e, cy_e, ax_e, ay_e, plus_x, minus_x, sx, ex, y;

	assign slot_free = !out_valid_q || result.ready;
	assign advance   = cur_valid_q && slot_free;
	assign last      = (idx_q == (flags_q.fill ? IDX_LAST_FILL : IDX_LAST_OUTLINE));
	assign pop       = !qstat.empty && (!cur_valid_q || (advance && last));

	// Octant and span order of one iteration.
	always_comb begin
		if (flags_q.fill) begin
			x_uses_oy = (idx_q == idx_t'(0)) || (idx_q == IDX_LAST_FILL);
			x_neg     = 1'b0;
			y_neg     = idx_q[1];
		end else begin
			x_uses_oy = idx_q[0];
			x_neg     = idx_q[1];
			y_neg     = idx_q[2];
		end
	end

	assign ax      = x_uses_oy ? oy_q : ox_q;
	assign ay      = x_uses_oy ? ox_q : oy_q;
	assign cx_e    = {2'b00, cx_q};
	assign cy_e    = {2'b00, cy_q};
	assign ax_e    = {2'b00, ax};
	assign ay_e    = {2'b00, ay};
	assign plus_x  = cx_e + ax_e;
	assign minus_x = cx_e - ax_e;
	assign y       = y_neg ? (cy_e - ay_e) : (cy_e + ay_e);
	assign sx      = (flags_q.fill || x_neg) ? minus_x : plus_x;
	assign ex      = flags_q.fill ? plus_x : sx;

	assign result.valid        = out_valid_q;
	assign result.span_start_x = sx_q;
	assign result.span_end_x   = ex_q;
	assign result.row_y        = y_q;
	assign result.last_of_run  = last_q;
	assign result.circle_done  = done_q;

	// Job and output payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q    <= job_cx;
			cy_q    <= job_cy;
			ox_q    <= job_ox;
			oy_q    <= job_oy;
			flags_q <= job_flags;
		end
		if (advance) begin
			sx_q   <= sx;
			ex_q   <= ex;
			y_q    <= y;
			last_q <= last;
			done_q <= flags_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance) begin
				if (last) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + idx_t'(1);
				end
			end
			if (slot_free) begin
				out_valid_q <= advance;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/circle_outline_and_fill_rasterizer.sv
// Top level of the circle outline and fill rasterizer.
// Depends on cofr_pkg, cofr_in_if, cofr_out_if, cofr_front, cofr_queue, cofr_back.
//
//   channel   direction  moves                            width per request
//   item      sink       start or step request            mode, 3 x COORD_BITS, fill
//   result    source     one point or one span            3 x (COORD_BITS+2) signed, 2 flags
//
// Cycles: the front end takes one request per cycle while the job queue has room.
// An outline iteration yields eight points through the result register, a fill iteration
// four spans; a step with no circle in progress yields nothing.
// The single result register, one point or span per cycle while results are taken, sets the sustained rate.
// Reset: asynchronous, active low; clears circle state, queue and both valid flags.
// Stalls: a held result stalls the back end only; the front end keeps taking
// requests until the queue fills.
`default_nettype none

module circle_outline_and_fill_rasterizer #(
	parameter int COORD_BITS  = 11,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cofr_in_if.sink   item,
	cofr_out_if.source result
);
	import cofr_pkg::*;

	localparam int JW = 4 * COORD_BITS + $bits(cofr_flags_t);

	logic                  push, pop;
	logic [COORD_BITS-1:0] f_cx, f_cy, f_ox, f_oy;
	logic [COORD_BITS-1:0] b_cx, b_cy, b_ox, b_oy;
	cofr_flags_t           f_flags, b_flags;
	cofr_qstat_t           qstat;
	logic [JW-1:0]         q_wr, q_rd;

	// Classify the request, advance the decision term, hand off the iteration.
	cofr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.qstat     (qstat),
		.push      (push),
		.job_cx    (f_cx),
		.job_cy    (f_cy),
		.job_ox    (f_ox),
		.job_oy    (f_oy),
		.job_flags (f_flags)
	);

	// Pack an iteration: center, pre-update offsets, fill and done flags.
	assign q_wr = {f_cx, f_cy, f_ox, f_oy, f_flags};

	cofr_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (q_wr),
		.pop     (pop),
		.rd_data (q_rd),
		.qstat   (qstat)
	);

	assign {b_cx, b_cy, b_ox, b_oy, b_flags} = q_rd;

	// Expand each iteration into eight points or four spans.
	cofr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_cx    (b_cx),
		.job_cy    (b_cy),
		.job_ox    (b_ox),
		.job_oy    (b_oy),
		.job_flags (b_flags),
		.qstat     (qstat),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: rtl/cofr_checker.sv
// Port-level checks for the rasterizer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cofr_checker #(
	parameter int OUT_BITS = 13
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [OUT_BITS-1:0] start_x,
	input wire logic [OUT_BITS-1:0] end_x,
	input wire logic [OUT_BITS-1:0] row_y,
	input wire logic                last,
	input wire logic                done
);

	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(start_x) && $stable(end_x)
			&& $stable(row_y) && $stable(last) && $stable(done))
		else $error("result changed while stalled");

	// A span never runs right to left; a point has equal ends.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(start_x) <= $signed(end_x))
		else $error("span start beyond span end");

	// No result shows during reset.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	// The done flag is the same on every result of one run.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |-> done == $past(done))
		else $error("done flag changed within a run");

endmodule

bind circle_outline_and_fill_rasterizer cofr_checker #(.OUT_BITS(COORD_BITS + 2)) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.start_x   (result.span_start_x),
	.end_x     (result.span_end_x),
	.row_y     (result.row_y),
	.last      (result.last_of_run),
	.done      (result.circle_done)
);

`default_nettype wire
